// ----- rtl/msled_pkg.sv -----
// Shared word types and codes for the multi-strip LED serial driver.
package msled_pkg;

  localparam logic [1:0] KIND_SET   = 2'd0;
  localparam logic [1:0] KIND_GET   = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;
  localparam logic [1:0] KIND_TICK  = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [10:0] pixel_index;
    logic [6:0]  green;
    logic [6:0]  red;
    logic [6:0]  blue;
  } in_word_t;

  typedef struct packed {
    logic [22:0] read_color;
    logic        in_range;
    logic [6:0]  data_lines;
    logic        clock_pulse;
    logic        busy_res;
    logic        frame_done;
  } out_word_t;

endpackage

// ----- rtl/multi_strip_led_serial_driver.sv -----
// Multi-strip LED serial driver: colour store, frame sequencer and bit serialiser.
//
// Colour store holds one row per LED position with all strips side by side
// (LEDS_PER_STRIP rows of STRIPS x 21 bits), so a tick reads the byte for every
// strip with a single access. Words of every kind are taken one per cycle while
// results are drained; each result appears in the cycle after its word is
// accepted, from the registered read of the store. After reset the store is
// cleared one row per cycle; in_ready stays low until that is done. A frame is
// 24*LEDS_PER_STRIP data ticks followed by 24*ceil(LEDS_PER_STRIP/64) latch
// ticks.
module multi_strip_led_serial_driver #(
  parameter int STRIPS         = 7,
  parameter int LEDS_PER_STRIP = 160
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  msled_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output msled_pkg::out_word_t out_data
);
  import msled_pkg::*;

  localparam int TOTAL        = STRIPS * LEDS_PER_STRIP;
  localparam int LW           = (LEDS_PER_STRIP > 1) ? $clog2(LEDS_PER_STRIP) : 1;
  localparam int SW           = (STRIPS > 1) ? $clog2(STRIPS) : 1;
  localparam int LATCH_PULSES = 24 * ((LEDS_PER_STRIP + 63) / 64);
  localparam int CW           = $clog2(LATCH_PULSES);
  localparam int NLINE        = (STRIPS < 7) ? STRIPS : 7;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_DATA  = 3'b010,
    PH_LATCH = 3'b100
  } phase_t;

  typedef logic [STRIPS-1:0][20:0] row_t;

  row_t mem [LEDS_PER_STRIP];

  // frame sequencer
  phase_t        phase_r, phase_nxt;
  logic [LW-1:0] led_r, led_nxt;
  logic [1:0]    comp_r, comp_nxt;
  logic [2:0]    bit_r, bit_nxt;
  logic [CW-1:0] latch_r, latch_nxt;

  // clearing pass
  logic          clr_act_r;
  logic [LW-1:0] clr_cnt_r;

  // result stage
  logic          s1_v_r;
  logic [1:0]    s1_kind_r;
  logic [SW-1:0] s1_strip_r;
  logic          s1_inr_r;
  logic          s1_busy_r;
  logic          s1_done_r;
  logic          s1_clk_r;
  logic          s1_dat_r;
  logic [1:0]    s1_comp_r;
  logic [2:0]    s1_bit_r;
  row_t          rdata_r;

  logic          acc;
  logic          busy;
  logic          tick_done;
  logic [31:0]   idx_w;
  logic [SW-1:0] idx_strip;
  logic [LW-1:0] idx_led;
  logic          idx_inr;
  logic          wr_en;
  logic [LW-1:0] rd_addr;

  assign in_ready = !clr_act_r && (!s1_v_r || out_ready);
  assign acc      = in_valid && in_ready;
  assign busy     = (phase_r != PH_IDLE);

  // split pixel number into strip and LED position
  always_comb begin
    idx_w     = 32'(in_data.pixel_index);
    idx_strip = '0;
    idx_led   = LW'(idx_w);
    for (int s = 1; s < STRIPS; s++) begin
      if (idx_w >= 32'(s * LEDS_PER_STRIP)) begin
        idx_strip = SW'(s);
        idx_led   = LW'(idx_w - 32'(s * LEDS_PER_STRIP));
      end
    end
    idx_inr = (idx_w < 32'(TOTAL));
  end

  assign wr_en   = acc && (in_data.kind == KIND_SET) && !busy && idx_inr;
  assign rd_addr = (in_data.kind == KIND_TICK) ? led_r : idx_led;

  always_comb begin
    phase_nxt = phase_r;
    led_nxt   = led_r;
    comp_nxt  = comp_r;
    bit_nxt   = bit_r;
    latch_nxt = latch_r;
    tick_done = 1'b0;
    if (acc) begin
      case (in_data.kind)
        KIND_START: begin
          if (!busy) begin
            phase_nxt = PH_DATA;
            led_nxt   = '0;
            comp_nxt  = '0;
            bit_nxt   = '0;
            latch_nxt = '0;
          end
        end
        KIND_TICK: begin
          case (phase_r)
            PH_DATA: begin
              if (bit_r == 3'd7) begin
                bit_nxt = '0;
                if (comp_r == 2'd2) begin
                  comp_nxt = '0;
                  if (led_r == LW'(LEDS_PER_STRIP - 1)) begin
                    led_nxt   = '0;
                    latch_nxt = '0;
                    phase_nxt = PH_LATCH;
                  end else begin
                    led_nxt = led_r + 1'b1;
                  end
                end else begin
                  comp_nxt = comp_r + 1'b1;
                end
              end else begin
                bit_nxt = bit_r + 1'b1;
              end
            end
            PH_LATCH: begin
              if (latch_r == CW'(LATCH_PULSES - 1)) begin
                tick_done = 1'b1;
                latch_nxt = '0;
                phase_nxt = PH_IDLE;
              end else begin
                latch_nxt = latch_r + 1'b1;
              end
            end
            default: phase_nxt = PH_IDLE;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      led_r     <= '0;
      comp_r    <= '0;
      bit_r     <= '0;
      latch_r   <= '0;
      clr_act_r <= 1'b1;
      clr_cnt_r <= '0;
      s1_v_r    <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      led_r   <= led_nxt;
      comp_r  <= comp_nxt;
      bit_r   <= bit_nxt;
      latch_r <= latch_nxt;
      if (clr_act_r) begin
        if (clr_cnt_r == LW'(LEDS_PER_STRIP - 1)) begin
          clr_act_r <= 1'b0;
        end else begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
        end
      end
      if (acc) begin
        s1_v_r <= 1'b1;
      end else if (out_ready) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  // colour store: one write (clear row or single lane) and one read per cycle
  always_ff @(posedge clk) begin
    if (clr_act_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (wr_en) begin
      mem[idx_led][idx_strip] <= {in_data.green, in_data.red, in_data.blue};
    end
    if (acc) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_kind_r  <= in_data.kind;
      s1_strip_r <= idx_strip;
      s1_inr_r   <= idx_inr;
      s1_busy_r  <= busy;
      s1_done_r  <= tick_done;
      s1_clk_r   <= (in_data.kind == KIND_TICK) && busy;
      s1_dat_r   <= (in_data.kind == KIND_TICK) && (phase_r == PH_DATA);
      s1_comp_r  <= comp_r;
      s1_bit_r   <= bit_r;
    end
  end

  always_comb begin
    logic [20:0] lane;
    logic [6:0]  ch;
    logic [7:0]  byt;
    out_data             = '0;
    ch                   = '0;
    byt                  = '0;
    out_data.busy_res    = s1_busy_r;
    out_data.clock_pulse = s1_clk_r;
    out_data.frame_done  = s1_done_r;
    lane = rdata_r[s1_strip_r];
    if ((s1_kind_r == KIND_GET) && s1_inr_r) begin
      out_data.in_range   = 1'b1;
      out_data.read_color = {lane[20:14], 1'b0, lane[13:7], 1'b0, lane[6:0]};
    end
    if ((s1_kind_r == KIND_TICK) && s1_dat_r) begin
      for (int s = 0; s < NLINE; s++) begin
        lane = rdata_r[SW'(s)];
        case (s1_comp_r)
          2'd0:    ch = lane[20:14];
          2'd1:    ch = lane[13:7];
          default: ch = lane[6:0];
        endcase
        // top bit of every byte is forced high, MSB goes out first
        byt = {1'b1, ch};
        out_data.data_lines[s] = byt[~s1_bit_r];
      end
    end
  end

  assign out_valid = s1_v_r;

endmodule

// ----- rtl/msled_chk.sv -----
// Port-level checks for the multi-strip LED serial driver, bound to the top level.
module msled_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input msled_pkg::out_word_t out_data
);
  import msled_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_done |-> out_data.clock_pulse && out_data.busy_res)
    else $error("frame end without clock pulse or busy");

  a_pulse_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.clock_pulse || out_data.data_lines != 7'd0) |->
      out_data.busy_res && out_data.clock_pulse)
    else $error("serial activity outside a frame");

  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.in_range |-> out_data.read_color == 23'd0)
    else $error("colour returned without a valid index");

endmodule

bind multi_strip_led_serial_driver msled_chk u_msled_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
